// ===== src/euc_pkg.sv =====
// Shared types and constants for the element uniqueness check unit.
// Used by euc_ctrl, euc_datapath and element_uniqueness_check_unit.
`timescale 1ns / 1ps

package euc_pkg;

   // Set store geometry
   localparam int MAX_ELEMENTS = 4096;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
   localparam int VALUE_W      = 32;
   localparam int COMPARE_W    = 23;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_READ,
      ST_ROW_LATCH,
      ST_SCAN,
      ST_REPORT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;        // transaction accepted: store element, reset search
      logic row_read;    // read the row element
      logic row_latch;   // capture row element, start column reads
      logic scan_step;   // one pairwise compare
      logic report;      // result goes out, set count cleared
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic few_elements; // fewer than two elements stored
      logic match;        // current pair is equal
      logic col_last;     // current column is the last element
      logic row_last;     // current row is the next to last element
   } status_type;

endpackage

// ===== src/euc_ctrl.sv =====
// Controller state machine for the element uniqueness check unit.
// Depends on euc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module euc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_last,
   input  euc_pkg::status_type status,
   output euc_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   euc_pkg::state_type state_ff;
   euc_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= euc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         euc_pkg::ST_IDLE: begin
            if (start && req_last) begin
               state_in = euc_pkg::ST_ROW_READ;
            end
         end
         euc_pkg::ST_ROW_READ: begin
            if (status.few_elements) begin
               state_in = euc_pkg::ST_REPORT;
            end else begin
               state_in = euc_pkg::ST_ROW_LATCH;
            end
         end
         euc_pkg::ST_ROW_LATCH: begin
            state_in = euc_pkg::ST_SCAN;
         end
         euc_pkg::ST_SCAN: begin
            if (status.match) begin
               state_in = euc_pkg::ST_REPORT;
            end else if (status.col_last) begin
               if (status.row_last) begin
                  state_in = euc_pkg::ST_REPORT;
               end else begin
                  state_in = euc_pkg::ST_ROW_READ;
               end
            end
         end
         euc_pkg::ST_REPORT: begin
            state_in = euc_pkg::ST_IDLE;
         end
         default: begin
            state_in = euc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         euc_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         euc_pkg::ST_ROW_READ: begin
            cmd.row_read = 1'b1;
         end
         euc_pkg::ST_ROW_LATCH: begin
            cmd.row_latch = 1'b1;
         end
         euc_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         euc_pkg::ST_REPORT: begin
            cmd.report = 1'b1;
            rsp_valid  = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== src/euc_datapath.sv =====
// Datapath for the element uniqueness check unit: element store, indices,
// comparator and compare counter. Depends on euc_pkg.
`timescale 1ns / 1ps

module euc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  euc_pkg::cmd_type              cmd,
   input  logic [euc_pkg::VALUE_W-1:0]   req_value,
   output euc_pkg::status_type           status,
   output logic                          rsp_has_duplicate,
   output logic [euc_pkg::COMPARE_W-1:0] rsp_compare_count
);

   logic [euc_pkg::VALUE_W-1:0]   mem [euc_pkg::MAX_ELEMENTS];
   logic [euc_pkg::VALUE_W-1:0]   rd_data_ff;
   logic [euc_pkg::VALUE_W-1:0]   ref_ff;
   logic [euc_pkg::ADDR_W-1:0]    rd_addr;
   logic [euc_pkg::COUNT_W-1:0]   count_ff;
   logic [euc_pkg::ADDR_W-1:0]    row_ff;
   logic [euc_pkg::ADDR_W-1:0]    col_ff;
   logic [euc_pkg::COMPARE_W-1:0] compares_ff;
   logic                          found_ff;
   logic                          has_room;
   logic [euc_pkg::ADDR_W-1:0]    row_next;
   logic [euc_pkg::ADDR_W-1:0]    col_next;

   assign has_room = count_ff < euc_pkg::COUNT_W'(euc_pkg::MAX_ELEMENTS);
   assign row_next = row_ff + 1'b1;
   assign col_next = col_ff + 1'b1;

   // Read address select
   always_comb begin
      if (cmd.row_read) begin
         rd_addr = row_ff;
      end else if (cmd.row_latch) begin
         rd_addr = row_next;
      end else begin
         rd_addr = col_next;
      end
   end

   // Element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         mem[count_ff[euc_pkg::ADDR_W-1:0]] <= req_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Element count (control)
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.report) begin
         count_ff <= '0;
      end else if (cmd.load && has_room) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Search indices, row element and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff      <= '0;
         compares_ff <= '0;
         found_ff    <= 1'b0;
      end
      if (cmd.row_latch) begin
         ref_ff <= rd_data_ff;
         col_ff <= row_next;
      end
      if (cmd.scan_step) begin
         compares_ff <= compares_ff + 1'b1;
         col_ff      <= col_next;
         if (status.match) begin
            found_ff <= 1'b1;
         end else if (status.col_last) begin
            row_ff <= row_next;
         end
      end
   end

   // Status toward the controller
   assign status.few_elements = count_ff < euc_pkg::COUNT_W'(2);
   assign status.match        = rd_data_ff == ref_ff;
   assign status.col_last     = {1'b0, col_ff} == (count_ff - euc_pkg::COUNT_W'(1));
   assign status.row_last     = {1'b0, row_ff} == (count_ff - euc_pkg::COUNT_W'(2));

   assign rsp_has_duplicate = found_ff;
   assign rsp_compare_count = compares_ff;

endmodule

// ===== src/element_uniqueness_check_unit.sv =====
// Element uniqueness check unit: loads a set of words one per cycle, then
// searches all pairs in row-major order for the first equal pair.
// Search: with under two elements the row read goes straight to report; else each
// row element is read, latched and compared with each later one, stopping early at
// a match, then reported. One element transaction per cycle while loading;
// busy holds start off during the search. Result strobe lasts one cycle, no stall.
// Reset clears the controller and the element count; the store is not cleared.
`timescale 1ns / 1ps

module element_uniqueness_check_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [euc_pkg::VALUE_W-1:0]   req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic                          rsp_has_duplicate,
   output logic [euc_pkg::COMPARE_W-1:0] rsp_compare_count
);

   euc_pkg::cmd_type    cmd;
   euc_pkg::status_type status;

   // Controller
   euc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath
   euc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_value         (req_value),
      .status            (status),
      .rsp_has_duplicate (rsp_has_duplicate),
      .rsp_compare_count (rsp_compare_count)
   );

endmodule

// ===== sim/tb_element_uniqueness_check_unit.sv =====
// Testbench for element_uniqueness_check_unit: sends sets of words through the
// start/busy command port and checks each duplicate verdict against a software scan.
// Depends on euc_pkg and the element_uniqueness_check_unit RTL.
`timescale 1ns / 1ps

module tb_element_uniqueness_check_unit;

   localparam int RANDOM_ITEMS   = 1340;
   localparam int LONG_SET_SIZE  = 256;
   localparam int MAX_REPORTED   = 10;
   localparam int SETTLE_CYCLES  = 16;

   // One verdict of the block: duplicate flag and comparisons made
   typedef struct {
      logic                          has_dup;
      logic [euc_pkg::COMPARE_W-1:0] compares;
   } verdict_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [euc_pkg::VALUE_W-1:0]   req_value;
   logic                          req_last;
   logic                          rsp_valid;
   logic                          rsp_has_duplicate;
   logic [euc_pkg::COMPARE_W-1:0] rsp_compare_count;

   logic [euc_pkg::VALUE_W-1:0] stored_words[$];     // elements of the set being loaded
   verdict_type                 pending_verdicts[$]; // verdicts not yet seen on rsp_
   int                          mismatch_count = 0;
   int                          burst_left = 0;

   element_uniqueness_check_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_has_duplicate (rsp_has_duplicate),
      .rsp_compare_count (rsp_compare_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run limit, far above the slowest legal run
   initial begin
      #50000000;
      $display("FAILURE");
      $finish;
   end

   // Row-major pair scan over the stored set, stopping at the first equal pair
   function automatic verdict_type scan_for_duplicate();
      verdict_type verdict;
      int          n;
      int          count;
      bit          found;
      n = stored_words.size();
      count = 0;
      found = 1'b0;
      for (int i = 0; i < n && !found; i++) begin
         for (int j = i + 1; j < n; j++) begin
            count++;
            if (stored_words[i] == stored_words[j]) begin
               found = 1'b1;
               break;
            end
         end
      end
      verdict.has_dup  = found;
      verdict.compares = count[euc_pkg::COMPARE_W-1:0];
      return verdict;
   endfunction

   // Send one element; the sender may idle between bursts of random length
   task automatic send_element(input logic [euc_pkg::VALUE_W-1:0] value,
                               input logic last_flag);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 200)
                                                  : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            start     <= 1'b0;
            req_value <= $urandom;
            req_last  <= 1'($urandom_range(0, 1));
         end
      end
      burst_left--;
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      req_last  <= last_flag;
      // transaction taken at the first rising edge with busy low
      do @(posedge clock); while (busy);
      // elements beyond the store depth are dropped
      if (stored_words.size() < euc_pkg::MAX_ELEMENTS)
         stored_words.push_back(value);
      if (last_flag) begin
         pending_verdicts.push_back(scan_for_duplicate());
         stored_words.delete();
      end
   endtask

   task automatic send_set(input logic [euc_pkg::VALUE_W-1:0] words[$]);
      foreach (words[k])
         send_element(words[k], k == words.size() - 1);
   endtask

   // Compare each result with the oldest pending verdict
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected result: dup=%0b count=%0d",
                        rsp_has_duplicate, rsp_compare_count);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_has_duplicate !== want.has_dup || rsp_compare_count !== want.compares) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display("mismatch: expected dup=%0b count=%0d, got dup=%0b count=%0d",
                           want.has_dup, want.compares, rsp_has_duplicate,
                           rsp_compare_count);
            end
         end
      end
   end

   // Single elements, two-element sets, field extremes, match positions
   task automatic test_directed();
      send_set('{32'h0000_0000});
      send_set('{32'hFFFF_FFFF});
      send_set('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_set('{32'h0000_0000, 32'hFFFF_FFFF});
      send_set('{32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
      send_set('{32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h5A5A_5A5A});
      send_set('{32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'h0000_0000});
      send_set('{32'h0000_0003, 32'h8000_0001, 32'h0000_0007, 32'h8000_0001});
   endtask

   // One long set with no duplicate: full quadratic scan
   task automatic test_long_unique_set();
      logic [euc_pkg::VALUE_W-1:0] base;
      base = $urandom;
      for (int k = 0; k < LONG_SET_SIZE; k++)
         send_element(base + euc_pkg::VALUE_W'(k) * 32'h9E37_79B9,
                      k == LONG_SET_SIZE - 1);
   endtask

   // Random sets: mostly small, a few large, with several duplicate patterns
   task automatic test_random_sets();
      logic [euc_pkg::VALUE_W-1:0] words[$];
      logic [euc_pkg::VALUE_W-1:0] pool[4];
      int                          sent;
      int                          size;
      int                          mode;
      int                          dst;
      int                          src;
      int                          pick;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            size = $urandom_range(1, 8);
         else if (pick < 95)
            size = $urandom_range(9, 40);
         else
            size = $urandom_range(41, 160);
         mode = $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 0)
            pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
         else
            pool = '{$urandom, $urandom, $urandom, $urandom};
         words.delete();
         for (int k = 0; k < size; k++) begin
            case (mode)
               0, 2: words.push_back($urandom);
               1: words.push_back(pool[$urandom_range(0, 3)]);
               default: words.push_back(euc_pkg::VALUE_W'($urandom_range(0, size)));
            endcase
         end
         // plant one copy of an earlier element
         if (mode == 2 && size >= 2) begin
            dst = $urandom_range(1, size - 1);
            src = $urandom_range(0, dst - 1);
            words[dst] = words[src];
         end
         send_set(words);
         sent += size;
      end
   endtask

   // Main sequence
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      req_last  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_unique_set();
      test_random_sets();

      @(negedge clock);
      start <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
